// ===== hdl/alu_with_condition_flags_macros.svh =====
// Assertion macros used by the top level of the ALU with condition flags RTL.
`ifndef ALU_WITH_CONDITION_FLAGS_MACROS_SVH
`define ALU_WITH_CONDITION_FLAGS_MACROS_SVH

// Checks that the antecedent implies the consequent in the same cycle.
`define AWCF_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed in same cycle");

// Checks that the antecedent implies the consequent in the next cycle.
`define AWCF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed in next cycle");

`endif

// ===== hdl/awcf_pkg.sv =====
// Package with operation codes, width codes and types for the ALU with condition flags.
`default_nettype none
package awcf_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_AND = 3'd2;
  localparam logic [2:0] KIND_OR  = 3'd3;
  localparam logic [2:0] KIND_XOR = 3'd4;
  localparam logic [2:0] KIND_INC = 3'd5;
  localparam logic [2:0] KIND_DEC = 3'd6;

  localparam logic [1:0] WIDTH_8  = 2'd0;
  localparam logic [1:0] WIDTH_16 = 2'd1;

  localparam int HALF_BIT = 4;

  localparam logic [5:0] MASK_ALL      = 6'h3F;
  localparam logic [5:0] MASK_NO_CARRY = 6'h3E;
  localparam logic [5:0] MASK_NONE     = 6'h00;

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  width_sel;
    logic [31:0] target_value;
    logic [31:0] source_value;
    logic        carry_in;
  } awcf_req_t;

  typedef struct packed {
    logic [5:0]  flag_write_mask;
    logic        carry_flag;
    logic        subtract_flag;
    logic        overflow_parity_flag;
    logic        half_flag;
    logic        zero_flag;
    logic        sign_flag;
    logic [31:0] result_value;
  } awcf_res_t;

endpackage
`default_nettype wire

// ===== hdl/awcf_core.sv =====
// Combinational ALU datapath with flag and flag write mask generation.
`default_nettype none
module awcf_core
  import awcf_pkg::*;
(
  input  var awcf_req_t req,
  input  wire           undefined_flag_value,
  output awcf_res_t     res
);

  function automatic logic msb_at(input logic [31:0] v, input logic [1:0] w);
    case (w)
      WIDTH_8:  msb_at = v[7];
      WIDTH_16: msb_at = v[15];
      default:  msb_at = v[31];
    endcase
  endfunction

  function automatic logic carry_at(input logic [32:0] v, input logic [1:0] w);
    case (w)
      WIDTH_8:  carry_at = v[8];
      WIDTH_16: carry_at = v[16];
      default:  carry_at = v[32];
    endcase
  endfunction

  logic [31:0] wmask;
  logic [31:0] t;
  logic [31:0] s;
  logic        cin;
  logic [32:0] sum;
  logic [32:0] dif;
  logic [31:0] add_v;
  logic [31:0] sub_v;
  logic        is32;
  logic [31:0] r;
  logic        hf;
  logic        vf;
  logic        nf;
  logic        cf;
  logic [5:0]  mask;

  always_comb begin
    case (req.width_sel)
      WIDTH_8:  wmask = 32'h0000_00FF;
      WIDTH_16: wmask = 32'h0000_FFFF;
      default:  wmask = 32'hFFFF_FFFF;
    endcase
    is32  = (req.width_sel != WIDTH_8) && (req.width_sel != WIDTH_16);
    t     = req.target_value & wmask;
    s     = req.source_value & wmask;
    cin   = ((req.kind == KIND_ADD) || (req.kind == KIND_SUB)) ? req.carry_in : 1'b0;
    sum   = {1'b0, t} + {1'b0, s} + {32'd0, cin};
    dif   = {1'b0, t} - {1'b0, s} - {32'd0, cin};
    add_v = sum[31:0] & wmask;
    sub_v = dif[31:0] & wmask;

    r    = t;
    hf   = 1'b0;
    vf   = 1'b0;
    nf   = 1'b0;
    cf   = 1'b0;
    mask = MASK_NONE;

    case (req.kind)
      KIND_ADD: begin
        r    = add_v;
        cf   = carry_at(sum, req.width_sel);
        vf   = msb_at((t ^ add_v) & (s ^ add_v), req.width_sel);
        hf   = is32 ? undefined_flag_value : (t[HALF_BIT] ^ s[HALF_BIT] ^ add_v[HALF_BIT]);
        mask = MASK_ALL;
      end
      KIND_SUB: begin
        r    = sub_v;
        cf   = carry_at(dif, req.width_sel);
        nf   = 1'b1;
        vf   = msb_at((t ^ s) & (t ^ sub_v), req.width_sel);
        hf   = is32 ? undefined_flag_value : (t[HALF_BIT] ^ s[HALF_BIT] ^ sub_v[HALF_BIT]);
        mask = MASK_ALL;
      end
      KIND_AND, KIND_OR, KIND_XOR: begin
        if (req.kind == KIND_AND) begin
          r = t & s;
        end else if (req.kind == KIND_OR) begin
          r = t | s;
        end else begin
          r = t ^ s;
        end
        vf   = is32 ? undefined_flag_value : ~(^r);
        hf   = (req.kind == KIND_AND);
        mask = MASK_ALL;
      end
      KIND_INC: begin
        r = add_v;
        if (req.width_sel == WIDTH_8) begin
          vf   = msb_at((t ^ add_v) & (s ^ add_v), req.width_sel);
          hf   = t[HALF_BIT] ^ s[HALF_BIT] ^ add_v[HALF_BIT];
          mask = MASK_NO_CARRY;
        end
      end
      KIND_DEC: begin
        r = sub_v;
        if (req.width_sel == WIDTH_8) begin
          nf   = 1'b1;
          vf   = msb_at((t ^ s) & (t ^ sub_v), req.width_sel);
          hf   = t[HALF_BIT] ^ s[HALF_BIT] ^ sub_v[HALF_BIT];
          mask = MASK_NO_CARRY;
        end
      end
      default: begin
        r    = t;
        mask = MASK_NONE;
      end
    endcase

    res.result_value         = r;
    res.sign_flag            = mask[5] & msb_at(r, req.width_sel);
    res.zero_flag            = mask[4] & (r == 32'd0);
    res.half_flag            = mask[3] & hf;
    res.overflow_parity_flag = mask[2] & vf;
    res.subtract_flag        = mask[1] & nf;
    res.carry_flag           = mask[0] & cf;
    res.flag_write_mask      = mask;
  end

endmodule
`default_nettype wire

// ===== hdl/alu_with_condition_flags.sv =====
// Top level of the ALU with condition flags: request register, datapath, result register.
// An accepted request is held in the request register, and its result in the result register, before it is output.
// Throughput is one request per cycle while the output does not stall; the request
// and result registers form a two-stage pipeline whose advance is set by the output
// stall alone. Reset (synchronous, active high) empties both stages and clears the
// undefined flag value register to zero.
`default_nettype none
`include "alu_with_condition_flags_macros.svh"
module alu_with_condition_flags
  import awcf_pkg::*;
(
  input  wire        clk,
  input  wire        rst,
  input  wire        s_tvalid,
  output logic       s_tready,
  // [31:0] target_value, [63:32] source_value, [64] carry_in, [71:65] zero
  input  wire [71:0] s_tdata,
  // [2:0] kind, [4:3] width_sel
  input  wire [4:0]  s_tuser,
  output logic       m_tvalid,
  input  wire        m_tready,
  // [31:0] result_value, [32] sign_flag, [33] zero_flag, [34] half_flag,
  // [35] overflow_parity_flag, [36] subtract_flag, [37] carry_flag,
  // [43:38] flag_write_mask, [47:44] zero
  output logic [47:0] m_tdata,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire        cfg_data
);

  logic      undef_value;
  logic      in_valid;
  awcf_req_t in_req;
  logic      out_valid;
  awcf_res_t out_res;
  awcf_res_t core_res;
  logic      out_ready;
  logic      advance;
  logic [5:0] out_mask_by_flag;

  assign out_ready = !out_valid || m_tready;
  assign advance   = in_valid && out_ready;
  assign s_tready  = !in_valid || out_ready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      undef_value <= 1'b0;
    end else if (cfg_valid) begin
      undef_value <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req.kind         <= s_tuser[2:0];
      in_req.width_sel    <= s_tuser[4:3];
      in_req.target_value <= s_tdata[31:0];
      in_req.source_value <= s_tdata[63:32];
      in_req.carry_in     <= s_tdata[64];
    end
  end

  awcf_core u_core (
    .req                  (in_req),
    .undefined_flag_value (undef_value),
    .res                  (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= core_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'd0, out_res.flag_write_mask, out_res.carry_flag,
                     out_res.subtract_flag, out_res.overflow_parity_flag,
                     out_res.half_flag, out_res.zero_flag, out_res.sign_flag,
                     out_res.result_value};

  // The mask bits reordered to line up with the flag bits [37:32] of the output.
  assign out_mask_by_flag = {m_tdata[38], m_tdata[39], m_tdata[40],
                             m_tdata[41], m_tdata[42], m_tdata[43]};

  `AWCF_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, in_valid)
  `AWCF_ASSERT_NEXT(a_stall_keeps_request, in_valid && !out_ready, in_valid && $stable(in_req))
  `AWCF_ASSERT_SAME(a_unwritten_flags_zero, m_tvalid, (m_tdata[37:32] & ~out_mask_by_flag) == 6'd0)
  `AWCF_ASSERT_SAME(a_zero_flag_result, m_tvalid && m_tdata[33], m_tdata[31:0] == 32'd0)

endmodule
`default_nettype wire
